// ----- sv/toc_pkg.sv -----
// Shared types and arithmetic step functions for track_outline_corners.
// No dependencies; imported by the top level.
package toc_pkg;

	localparam int CoordW = 31;
	localparam int WidthW = 29;
	localparam int CornerW = 32;
	localparam int DivSteps = 58;   // quotient bits of floor(h^2*m^2/d)
	localparam int SqrtSteps = 29;  // root bits of the half-width scale
	localparam int InDataW = 160;
	localparam int OutDataW = 256;

	typedef struct packed {
		logic signed [CoordW-1:0] sx;
		logic signed [CoordW-1:0] sy;
		logic signed [CoordW-1:0] ex;
		logic signed [CoordW-1:0] ey;
		logic [WidthW-1:0] h;
		logic vert;
		logic horiz;
		logic plus_first;
		logic neg_py;
	} side_t;

	typedef struct packed {
		logic [62:0] r;
		logic [57:0] q;
	} div_res_t;

	typedef struct packed {
		logic [57:0] rem;
		logic [28:0] root;
	} sqrt_res_t;

	// One radix-2 step of floor(prefix*m2/d); remainder stays below d since m2 <= d.
	function automatic div_res_t div_step(logic [62:0] r, logic [57:0] q,
			logic [61:0] m2, logic [62:0] d, logic b);
		logic [64:0] t;
		logic [64:0] d1;
		logic [64:0] d2;
		div_res_t res;
		d1 = {2'b00, d};
		d2 = {1'b0, d, 1'b0};
		t = {1'b0, r, 1'b0} + (b ? {3'b000, m2} : 65'd0);
		if (t >= d2) begin
			res.r = 63'(t - d2);
			res.q = {q[56:0], 1'b0} + 58'd2;
		end else if (t >= d1) begin
			res.r = 63'(t - d1);
			res.q = {q[56:0], 1'b0} + 58'd1;
		end else begin
			res.r = t[62:0];
			res.q = {q[56:0], 1'b0};
		end
		return res;
	endfunction

	// One bit of integer square root, remainder form: try root bit j.
	function automatic sqrt_res_t sqrt_step(logic [57:0] rem, logic [28:0] root, int j);
		logic [59:0] t;
		sqrt_res_t res;
		t = ({31'd0, root} << (j + 1)) | (60'd1 << (2 * j));
		res.rem = rem;
		res.root = root;
		if ({2'b00, rem} >= t) begin
			res.rem = 58'({2'b00, rem} - t);
			res.root = root | (29'd1 << j);
		end
		return res;
	endfunction

endpackage

// ----- sv/track_outline_corners.sv -----
// Top level of track_outline_corners: track in, four rectangle corners out.
// Depends on toc_pkg (types, divide and square-root step functions).
//
// Usage:
//   s_* channel: one track per beat. m_* channel: one corner set per beat.
//   cfg channel: writes width_growth; always ready, write only while idle.
// Operation: half width h = (track_width + width_growth) / 2. Diagonal
//   offsets are isqrt(floor(h^2*m^2/d)) with d = dx^2+dy^2, which equals
//   floor(h*m/sqrt(d)) exactly. The quotient comes from a 58-stage radix-2
//   multiply-divide pipeline, the root from a 29-stage square-root pipeline.
// Pipeline: 91 register stages: 3 setup, 58 divide, 29 root, output register.
// Throughput: one track per cycle while the output is not stalled; every
//   divide or root stage is one bit step of that unit.
// Reset: arst_n clears all valid bits and width_growth to zero.
// Stall: when the output holds an untaken beat and m_tready is low, the
//   whole pipeline holds and s_tready drops; nothing is lost or repeated.
module track_outline_corners
	import toc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// start_x[30:0], start_y[61:31], end_x[92:62], end_y[123:93],
	// track_width[152:124], zero fill above
	input  logic [InDataW-1:0]  s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	// corner1_x, corner1_y, corner2_x, corner2_y, corner3_x, corner3_y,
	// corner4_x, corner4_y, 32 bits each from bit 0 up
	output logic [OutDataW-1:0] m_tdata,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [WidthW-1:0]   cfg_data
);

	logic en;
	logic [WidthW-1:0] growth_q;

	// stage 1
	logic v_s1;
	logic signed [CoordW-1:0] sx_s1, sy_s1, ex_s1, ey_s1;
	logic [WidthW:0] w_s1;
	logic signed [CoordW:0] dx_s1, dy_s1;
	// stage 2
	logic v_s2;
	side_t side_s2;
	logic [57:0] h2_s2;
	logic [61:0] m2x_s2, m2y_s2;
	// stage 3
	logic v_s3;
	side_t side_s3;
	logic [57:0] h2_s3;
	logic [61:0] m2x_s3, m2y_s3;
	logic [62:0] d_s3;
	// divide stages
	logic v_dv [DivSteps];
	side_t side_dv [DivSteps];
	logic [57:0] h2_dv [DivSteps];
	logic [61:0] m2x_dv [DivSteps];
	logic [61:0] m2y_dv [DivSteps];
	logic [62:0] d_dv [DivSteps];
	logic [62:0] rx_dv [DivSteps];
	logic [62:0] ry_dv [DivSteps];
	logic [57:0] qx_dv [DivSteps];
	logic [57:0] qy_dv [DivSteps];
	// root stages
	logic v_sq [SqrtSteps];
	side_t side_sq [SqrtSteps];
	logic [57:0] remx_sq [SqrtSteps];
	logic [57:0] remy_sq [SqrtSteps];
	logic [28:0] rootx_sq [SqrtSteps];
	logic [28:0] rooty_sq [SqrtSteps];

	logic out_valid_q;
	logic [OutDataW-1:0] out_data_q;

	assign en = !out_valid_q || m_tready;
	assign s_tready = en;
	assign cfg_ready = 1'b1;
	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			growth_q <= '0;
		end else if (cfg_valid) begin
			growth_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	logic signed [CoordW-1:0] in_sx, in_sy, in_ex, in_ey;
	logic [WidthW-1:0] in_w;
	assign in_sx = s_tdata[30:0];
	assign in_sy = s_tdata[61:31];
	assign in_ex = s_tdata[92:62];
	assign in_ey = s_tdata[123:93];
	assign in_w = s_tdata[152:124];

	// stage 2 classification
	logic [CoordW-1:0] adx, ady;
	logic dx_zero, dy_zero, dx_pos, dy_pos;
	assign dx_zero = (dx_s1 == '0);
	assign dy_zero = (dy_s1 == '0);
	assign dx_pos = !dx_s1[CoordW] && !dx_zero;
	assign dy_pos = !dy_s1[CoordW] && !dy_zero;
	assign adx = dx_s1[CoordW] ? CoordW'(-dx_s1) : dx_s1[CoordW-1:0];
	assign ady = dy_s1[CoordW] ? CoordW'(-dy_s1) : dy_s1[CoordW-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s1 <= in_sx;
			sy_s1 <= in_sy;
			ex_s1 <= in_ex;
			ey_s1 <= in_ey;
			w_s1 <= {1'b0, in_w} + {1'b0, growth_q};
			dx_s1 <= (CoordW+1)'(in_ex) - (CoordW+1)'(in_sx);
			dy_s1 <= (CoordW+1)'(in_ey) - (CoordW+1)'(in_sy);

			side_s2.sx <= sx_s1;
			side_s2.sy <= sy_s1;
			side_s2.ex <= ex_s1;
			side_s2.ey <= ey_s1;
			side_s2.h <= w_s1[WidthW:1];
			side_s2.vert <= dx_zero;
			side_s2.horiz <= !dx_zero && dy_zero;
			side_s2.neg_py <= (dx_pos == dy_pos);
			if (dx_zero) begin
				side_s2.plus_first <= !dy_pos;
			end else if (dy_zero) begin
				side_s2.plus_first <= dx_pos;
			end else begin
				side_s2.plus_first <= !dy_pos;
			end
			h2_s2 <= {29'd0, w_s1[WidthW:1]} * {29'd0, w_s1[WidthW:1]};
			m2x_s2 <= {31'd0, ady} * {31'd0, ady};
			m2y_s2 <= {31'd0, adx} * {31'd0, adx};

			side_s3 <= side_s2;
			h2_s3 <= h2_s2;
			m2x_s3 <= m2x_s2;
			m2y_s3 <= m2y_s2;
			d_s3 <= {1'b0, m2x_s2} + {1'b0, m2y_s2};
		end
	end

	// divide pipeline: bit k consumes h^2 bit 57-k, most significant first
	genvar k;
	generate
		for (k = 0; k < DivSteps; k++) begin : g_div
			logic pv;
			side_t pside;
			logic [57:0] ph2, pqx, pqy;
			logic [61:0] pm2x, pm2y;
			logic [62:0] pd, prx, pry;
			div_res_t resx, resy;
			if (k == 0) begin : g_first
				assign pv = v_s3;
				assign pside = side_s3;
				assign ph2 = h2_s3;
				assign pm2x = m2x_s3;
				assign pm2y = m2y_s3;
				assign pd = d_s3;
				assign prx = '0;
				assign pry = '0;
				assign pqx = '0;
				assign pqy = '0;
			end else begin : g_next
				assign pv = v_dv[k-1];
				assign pside = side_dv[k-1];
				assign ph2 = h2_dv[k-1];
				assign pm2x = m2x_dv[k-1];
				assign pm2y = m2y_dv[k-1];
				assign pd = d_dv[k-1];
				assign prx = rx_dv[k-1];
				assign pry = ry_dv[k-1];
				assign pqx = qx_dv[k-1];
				assign pqy = qy_dv[k-1];
			end
			assign resx = div_step(prx, pqx, pm2x, pd, ph2[DivSteps-1-k]);
			assign resy = div_step(pry, pqy, pm2y, pd, ph2[DivSteps-1-k]);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_dv[k] <= 1'b0;
				end else if (en) begin
					v_dv[k] <= pv;
				end
			end
			always_ff @(posedge clk) begin
				if (en) begin
					side_dv[k] <= pside;
					h2_dv[k] <= ph2;
					m2x_dv[k] <= pm2x;
					m2y_dv[k] <= pm2y;
					d_dv[k] <= pd;
					rx_dv[k] <= resx.r;
					ry_dv[k] <= resy.r;
					qx_dv[k] <= resx.q;
					qy_dv[k] <= resy.q;
				end
			end
		end
	endgenerate

	// root pipeline: stage i settles root bit 28-i
	genvar i;
	generate
		for (i = 0; i < SqrtSteps; i++) begin : g_sqrt
			logic pv;
			side_t pside;
			logic [57:0] premx, premy;
			logic [28:0] prootx, prooty;
			sqrt_res_t resx, resy;
			if (i == 0) begin : g_first
				assign pv = v_dv[DivSteps-1];
				assign pside = side_dv[DivSteps-1];
				assign premx = qx_dv[DivSteps-1];
				assign premy = qy_dv[DivSteps-1];
				assign prootx = '0;
				assign prooty = '0;
			end else begin : g_next
				assign pv = v_sq[i-1];
				assign pside = side_sq[i-1];
				assign premx = remx_sq[i-1];
				assign premy = remy_sq[i-1];
				assign prootx = rootx_sq[i-1];
				assign prooty = rooty_sq[i-1];
			end
			assign resx = sqrt_step(premx, prootx, SqrtSteps - 1 - i);
			assign resy = sqrt_step(premy, prooty, SqrtSteps - 1 - i);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_sq[i] <= 1'b0;
				end else if (en) begin
					v_sq[i] <= pv;
				end
			end
			always_ff @(posedge clk) begin
				if (en) begin
					side_sq[i] <= pside;
					remx_sq[i] <= resx.rem;
					remy_sq[i] <= resy.rem;
					rootx_sq[i] <= resx.root;
					rooty_sq[i] <= resy.root;
				end
			end
		end
	endgenerate

	// offset vector and corners
	side_t fs;
	logic signed [CornerW-1:0] hx, mx, my, px0, py0, px, py;
	logic signed [CornerW-1:0] csx, csy, cex, cey;
	assign fs = side_sq[SqrtSteps-1];
	assign hx = CornerW'({3'b000, fs.h});
	assign mx = CornerW'({3'b000, rootx_sq[SqrtSteps-1]});
	assign my = CornerW'({3'b000, rooty_sq[SqrtSteps-1]});
	assign csx = CornerW'(fs.sx);
	assign csy = CornerW'(fs.sy);
	assign cex = CornerW'(fs.ex);
	assign cey = CornerW'(fs.ey);

	always_comb begin
		priority if (fs.vert) begin
			px0 = hx;
			py0 = '0;
		end else if (fs.horiz) begin
			px0 = '0;
			py0 = hx;
		end else begin
			px0 = mx;
			py0 = fs.neg_py ? -my : my;
		end
		px = fs.plus_first ? px0 : -px0;
		py = fs.plus_first ? py0 : -py0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_sq[SqrtSteps-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= {csy - py, csx - px, cey - py, cex - px,
				cey + py, cex + px, csy + py, csx + px};
		end
	end

	// the input side only stalls behind a held output beat
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (out_valid_q && !m_tready))
		else $error("input stalled without a held output beat");

	// an accepted beat enters stage 1
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> v_s1)
		else $error("accepted beat missing from stage 1");

	// a held output freezes the pipeline valid bits
	assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(v_s1) && $stable(v_dv[DivSteps-1]) && $stable(v_sq[SqrtSteps-1])))
		else $error("pipeline moved during stall");

	// a new output beat comes from the last root stage
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(v_sq[SqrtSteps-1]))
		else $error("output beat without a source");

endmodule
